// ===== design/lpsd_pkg.sv =====
// Package for the length-prefixed, sum-checked deframer.
// Holds frame constants, the verdict status codes and the result word type.
// No dependencies.
package lpsd_pkg;

    localparam int LEN_BYTES = 2;
    localparam int SUM_BYTES = 2;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd270;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_LENGTH = 2'd1,
        ST_BAD_SUM    = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       is_verdict;
        status_t    frame_status;
    } result_t;

endpackage

// ===== design/lpsd_frame.sv =====
// Frame tracker: byte counter, captured length, running sum and checksum high byte.
// Produces at most one result word per stepped input word.
// Depends on lpsd_pkg.
module lpsd_frame
    import lpsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        abort,
    input  logic [15:0] max_len,
    output logic        res_valid,
    output result_t     res
);

    logic [16:0] byte_count_reg, byte_count_next;
    logic [15:0] declared_length_reg, declared_length_next;
    logic [15:0] running_sum_reg, running_sum_next;
    logic [7:0]  checksum_high_reg, checksum_high_next;

    logic [16:0] payload_end;
    logic        length_ok;
    logic [15:0] given_sum;

    assign payload_end = {1'b0, declared_length_reg} + 17'(LEN_BYTES);
    assign length_ok   = (declared_length_reg != 16'd0) && (declared_length_reg <= max_len);
    assign given_sum   = {checksum_high_reg, data_byte};

    always_comb
    begin
        byte_count_next      = byte_count_reg;
        declared_length_next = declared_length_reg;
        running_sum_next     = running_sum_reg;
        checksum_high_next   = checksum_high_reg;
        res_valid            = 1'b0;
        res.payload_byte     = 8'd0;
        res.is_verdict       = 1'b0;
        res.frame_status     = ST_OK;
        if (step)
        begin
            priority if (abort)
            begin
                byte_count_next      = 17'd0;
                declared_length_next = 16'd0;
                running_sum_next     = 16'd0;
                checksum_high_next   = 8'd0;
            end
            else if (byte_count_reg == 17'd0)
            begin
                declared_length_next = {data_byte, 8'd0};
                byte_count_next      = 17'd1;
            end
            else if (byte_count_reg == 17'd1)
            begin
                declared_length_next = {declared_length_reg[15:8], data_byte};
                byte_count_next      = 17'd2;
            end
            else if (byte_count_reg < payload_end)
            begin
                running_sum_next = running_sum_reg + {8'd0, data_byte};
                byte_count_next  = byte_count_reg + 17'd1;
                if (length_ok)
                begin
                    res_valid        = 1'b1;
                    res.payload_byte = data_byte;
                end
            end
            else if (byte_count_reg == payload_end)
            begin
                checksum_high_next = data_byte;
                byte_count_next    = byte_count_reg + 17'd1;
            end
            else
            begin
                res_valid      = 1'b1;
                res.is_verdict = 1'b1;
                if (!length_ok)
                    res.frame_status = ST_BAD_LENGTH;
                else if (given_sum != running_sum_reg)
                    res.frame_status = ST_BAD_SUM;
                else
                    res.frame_status = ST_OK;
                byte_count_next      = 17'd0;
                declared_length_next = 16'd0;
                running_sum_next     = 16'd0;
                checksum_high_next   = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg      <= 17'd0;
            declared_length_reg <= 16'd0;
            running_sum_reg     <= 16'd0;
            checksum_high_reg   <= 8'd0;
        end
        else
        begin
            byte_count_reg      <= byte_count_next;
            declared_length_reg <= declared_length_next;
            running_sum_reg     <= running_sum_next;
            checksum_high_reg   <= checksum_high_next;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= ({1'b0, declared_length_reg} + 17'(LEN_BYTES + 1)))
        else $error("byte counter ran past the checksum");

    a_payload_only_with_good_length: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.is_verdict |-> length_ok)
        else $error("payload passed on for a bad length");

endmodule

// ===== design/length_prefixed_sum_checked_deframer_unit.sv =====
// An accepted input word waits in the input register, and its result word is loaded
// into the result register, which drives the output.
// Throughput: one input word per cycle; the input register and result register
// advance together whenever the result register is empty or being taken.
// Reset clears the frame state and the valid flags of both pipeline registers and sets
// the maximum payload length to 270. cfg_ready is always high, so the register is
// written whenever cfg_valid is high.
// Top level of the deframer; depends on lpsd_pkg and lpsd_frame.
module length_prefixed_sum_checked_deframer_unit
    import lpsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        abort,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  payload_byte,
    output logic        is_verdict,
    output logic [1:0]  frame_status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic        in_full_reg;
    logic [7:0]  in_byte_reg;
    logic        in_abort_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic [15:0] max_len_reg;

    logic        advance;
    logic        res_valid;
    result_t     res;

    assign advance   = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_full_reg && !advance;
    assign cfg_ready = 1'b1;

    lpsd_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .abort     (in_abort_reg),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            max_len_reg   <= MAX_PAYLOAD_RESET;
        end
        else
        begin
            if (!in_stall)
                in_full_reg <= in_valid;
            if (advance)
                out_valid_reg <= res_valid;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                max_len_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg  <= data_byte;
            in_abort_reg <= abort;
        end
        if (advance && res_valid)
            out_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign payload_byte = out_reg.payload_byte;
    assign is_verdict   = out_reg.is_verdict;
    assign frame_status = out_reg.frame_status;

    a_verdict_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_verdict |-> payload_byte == 8'd0)
        else $error("verdict word carries a payload byte");

    a_payload_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_verdict |-> frame_status == ST_OK)
        else $error("payload word carries a status");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_full_reg)
        else $error("input register dropped a stalled word");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(out_reg))
        else $error("result register changed while stalled");

endmodule
